// ===== hdl/cmre_pkg.sv =====
// ----------------------------------------------------------------------------
// cmre_pkg
// Shared types and constants of the context modeled range encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cmre_pkg;

  localparam int DEF_MAX_CONTEXTS = 4096;
  localparam int DEF_MAX_SYMBOLS  = 64;
  localparam int HSPACE_W         = 17;   // holds the largest allowed context count
  localparam int DIV_W            = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [15:0] FREQ_STEP   = 16'd24;
  localparam int          FREQ_LIMIT  = 60000;
  localparam logic [31:0] EMIT_LIMIT  = 32'hFF00_0000;
  localparam logic [31:0] RANGE_MIN   = 32'h0100_0000;
  localparam logic [31:0] RANGE_INIT  = 32'hFFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_ALPHABET   = 3'd0;
  localparam logic [2:0] REG_HISTORY    = 3'd1;
  localparam logic [2:0] REG_POS_BUCKET = 3'd2;
  localparam logic [2:0] REG_CHG_BUCKET = 3'd3;
  localparam logic [2:0] REG_MAX_READ   = 3'd4;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  typedef struct packed {
    logic [6:0]  alphabet_size;
    logic [1:0]  history_order;
    logic [4:0]  position_buckets;
    logic [6:0]  change_buckets;
    logic [15:0] max_read_length;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] symbol;
    logic       read_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  lead_byte;
    logic [7:0]  fill_byte;
    logic [31:0] fill_count;
    logic        context_error;
    logic        last;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_ENCODE,
    CMD_FLUSH,
    CMD_ERROR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [5:0]            symbol;
    logic                  read_start;
    logic [HSPACE_W-1:0]   hspace;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/cmre_div.sv =====
// ----------------------------------------------------------------------------
// cmre_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_div #(
  parameter int W = cmre_pkg::DIV_W
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              busy,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] quo;
  logic [W-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [W:0]   trial;
  logic         fits;

  assign trial = {rem, quo[W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      rem  <= fits ? W'(trial - {1'b0, dvs}) : trial[W-1:0];
      quo  <= {quo[W-2:0], fits};
      cnt  <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

`default_nettype wire

// ===== hdl/cmre_queue.sv =====
// ----------------------------------------------------------------------------
// cmre_queue
// Short command queue between the classifier and the coder.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_queue #(
  parameter int DEPTH = cmre_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire cmre_pkg::cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output cmre_pkg::cmd_t       pop_cmd
);
  import cmre_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = fill != NW'(DEPTH);
  assign pop_valid  = fill != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + NW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cmre_front.sv =====
// ----------------------------------------------------------------------------
// cmre_front
// Accepts requests, checks the context count and classifies each request.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_front #(
  parameter int MAX_CONTEXTS = cmre_pkg::DEF_MAX_CONTEXTS,
  parameter int MAX_SYMBOLS  = cmre_pkg::DEF_MAX_SYMBOLS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmre_pkg::cfg_t     cfg,
  input  wire logic               enable,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire cmre_pkg::in_item_t in_item,
  output logic                    cmd_valid,
  input  wire logic               cmd_ready,
  output cmre_pkg::cmd_t          cmd
);
  import cmre_pkg::*;

  localparam int VW = $clog2(MAX_CONTEXTS + 2);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC,
    F_SEND
  } fstate_t;

  fstate_t     state;
  in_item_t    item;
  logic [VW-1:0] val;
  logic [VW-1:0] hsp;
  logic [2:0]  step;
  logic [6:0]  factor;
  logic [VW+6:0] prod;
  logic [VW-1:0] clamped;
  logic        bad_cfg;
  logic        drop;
  cmd_kind_t   kind;

  always_comb begin
    if (step < {1'b0, cfg.history_order}) begin
      factor = cfg.alphabet_size;
    end else if (step == {1'b0, cfg.history_order}) begin
      factor = {2'b00, cfg.position_buckets};
    end else begin
      factor = cfg.change_buckets;
    end
  end

  assign prod    = (VW+7)'(val) * (VW+7)'(factor);
  // saturate just above the limit so the product never grows further
  assign clamped = (prod > (VW+7)'(MAX_CONTEXTS)) ? VW'(MAX_CONTEXTS + 1) : prod[VW-1:0];

  assign bad_cfg = (cfg.alphabet_size == 7'd0) || (cfg.alphabet_size > 7'(MAX_SYMBOLS))
                || (cfg.position_buckets == 5'd0) || (cfg.change_buckets == 7'd0)
                || (val > VW'(MAX_CONTEXTS));

  always_comb begin
    drop = 1'b0;
    if (item.opcode == OP_FLUSH) begin
      kind = CMD_FLUSH;
    end else if (bad_cfg) begin
      kind = CMD_ERROR;
    end else begin
      kind = CMD_ENCODE;
      drop = {1'b0, item.symbol} >= cfg.alphabet_size;
    end
  end

  assign in_ready   = enable && (state == F_IDLE);
  assign cmd_valid  = (state == F_SEND) && !drop;
  assign cmd.kind       = kind;
  assign cmd.symbol     = item.symbol;
  assign cmd.read_start = item.read_start;
  assign cmd.hspace     = HSPACE_W'(hsp);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            item  <= in_item;
            val   <= VW'(1);
            hsp   <= VW'(1);
            step  <= 3'd0;
            state <= (in_item.opcode == OP_FLUSH) ? F_SEND : F_CALC;
          end
        end
        F_CALC: begin
          val  <= clamped;
          step <= step + 3'd1;
          if (step == {1'b0, cfg.history_order}) begin
            hsp <= val;
          end
          if (step == {1'b0, cfg.history_order} + 3'd1) begin
            state <= F_SEND;
          end
        end
        F_SEND: begin
          if (drop || cmd_ready) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cmre_back.sv =====
// ----------------------------------------------------------------------------
// cmre_back
// Coder: context build, model sum, range update, shifts and model update.
// ----------------------------------------------------------------------------
`default_nettype none

module cmre_back #(
  parameter int MAX_CONTEXTS = cmre_pkg::DEF_MAX_CONTEXTS,
  parameter int MAX_SYMBOLS  = cmre_pkg::DEF_MAX_SYMBOLS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire cmre_pkg::cfg_t cfg,
  output logic                ready_for_items,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire cmre_pkg::cmd_t cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output cmre_pkg::out_item_t out_item
);
  import cmre_pkg::*;

  localparam int CTXW  = $clog2(MAX_CONTEXTS + 1);
  localparam int SW    = $clog2(MAX_SYMBOLS + 1);
  localparam int DEPTH = MAX_CONTEXTS * MAX_SYMBOLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = 16 + SW;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_HIST, B_HIST_W, B_POS, B_POS_W, B_CTX1, B_CTX2, B_BASE,
    B_SUM, B_RDIV, B_RDIV_W, B_MUL, B_NORM, B_WRSYM, B_HALVE, B_HMUL, B_HMOD,
    B_HMOD_W, B_FLUSH, B_ERR, B_FIN
  } bstate_t;

  bstate_t state;

  // coder and read context
  logic [32:0]     low;
  logic [31:0]     coder_range;
  logic [7:0]      cached;
  logic [31:0]     pending;
  logic [CTXW-1:0] hist_idx;
  logic [5:0]      prev_sym;
  logic            prev_valid;
  logic [6:0]      chg;
  logic [15:0]     rpos;

  // per item working registers
  logic [5:0]      sym;
  logic [CTXW-1:0] hsp;
  logic [CTXW-1:0] hist;
  logic [4:0]      pb;
  logic [CTXW-1:0] ctx;
  logic [AW-1:0]   base;
  logic [SW-1:0]   idx;
  logic            rvalid_d;
  logic [SW-1:0]   ridx;
  logic [TW-1:0]   tot;
  logic [TW-1:0]   lo;
  logic [15:0]     fv;
  logic [31:0]     r;
  logic [CTXW+6:0] hprod;
  logic [2:0]      nshift;
  logic [AW-1:0]   clr_addr;

  // result held back until it is known whether it is the final one
  out_item_t held;
  logic      held_valid;

  // frequency store
  logic [15:0]   freq [DEPTH];
  logic [15:0]   rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;

  // divider
  logic        div_start;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic        div_busy;
  logic [31:0] div_q;
  logic [31:0] div_r;

  logic [15:0] scale;
  logic [6:0]  db;
  logic [6:0]  idx7;
  logic [6:0]  ridx7;
  logic        out_free;
  logic [31:0] lo32;
  logic        carry;
  logic        emit;
  logic        can_shift;
  logic        shift_go;
  out_item_t   shift_res;

  cmre_div #(.W(DIV_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign scale = (cfg.max_read_length == 16'd0) ? 16'd1 : cfg.max_read_length;
  assign db    = (chg >= cfg.change_buckets) ? cfg.change_buckets - 7'd1 : chg;
  assign idx7  = 7'(idx);
  assign ridx7 = 7'(ridx);

  always_comb begin
    div_start = 1'b0;
    div_a     = '0;
    div_b     = 32'd1;
    case (state)
      B_HIST: begin
        div_start = 1'b1;
        div_a     = 32'(hist_idx);
        div_b     = 32'(hsp);
      end
      B_POS: begin
        div_start = 1'b1;
        div_a     = 32'(rpos) * 32'(cfg.position_buckets);
        div_b     = 32'(scale);
      end
      B_RDIV: begin
        div_start = 1'b1;
        div_a     = coder_range;
        div_b     = 32'(tot);
      end
      B_HMOD: begin
        div_start = 1'b1;
        div_a     = 32'(hprod);
        div_b     = 32'(hsp);
      end
      default: ;
    endcase
  end

  // one coder shift
  assign lo32      = low[31:0];
  assign carry     = low[32];
  assign emit      = carry || (lo32 < EMIT_LIMIT);
  assign out_free  = !out_valid || out_ready;
  assign can_shift = !(emit && held_valid) || out_free;
  assign shift_go  = can_shift && (((state == B_NORM) && (coder_range < RANGE_MIN))
                                   || (state == B_FLUSH));
  assign shift_res.lead_byte     = cached + {7'd0, carry};
  assign shift_res.fill_byte     = 8'hFF + {7'd0, carry};
  assign shift_res.fill_count    = pending - 32'd1;
  assign shift_res.context_error = 1'b0;
  assign shift_res.last          = 1'b0;

  // store ports
  assign rd_addr = base + AW'(idx);
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_addr;
    wr_data = 16'd1;
    case (state)
      B_CLEAR: wr_en = 1'b1;
      B_WRSYM: begin
        wr_en   = 1'b1;
        wr_addr = base + AW'(sym);
        wr_data = fv + FREQ_STEP;
      end
      B_HALVE: begin
        wr_en   = rvalid_d;
        wr_addr = base + AW'(ridx);
        wr_data = {1'b0, rd_data[15:1]} | 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      freq[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= freq[rd_addr];
  end

  assign ready_for_items = state != B_CLEAR;
  assign cmd_ready       = state == B_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      held_valid  <= 1'b0;
      rvalid_d    <= 1'b0;
      low         <= '0;
      coder_range <= RANGE_INIT;
      cached      <= 8'd0;
      pending     <= 32'd1;
      hist_idx    <= '0;
      prev_sym    <= 6'd0;
      prev_valid  <= 1'b0;
      chg         <= 7'd0;
      rpos        <= 16'd0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (shift_go) begin
        if (emit) begin
          if (held_valid) begin
            out_valid <= 1'b1;
            out_item  <= held;
          end
          held       <= shift_res;
          held_valid <= 1'b1;
          cached     <= lo32[31:24];
          pending    <= 32'd1;
        end else begin
          pending <= pending + 32'd1;
        end
        low <= {1'b0, lo32[23:0], 8'd0};
      end

      unique case (state)
        B_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (cmd_valid) begin
            sym    <= cmd.symbol;
            hsp    <= CTXW'(cmd.hspace);
            nshift <= 3'd0;
            unique case (cmd.kind)
              CMD_FLUSH: state <= B_FLUSH;
              CMD_ERROR: state <= B_ERR;
              default: begin
                if (cmd.read_start) begin
                  hist_idx   <= '0;
                  prev_valid <= 1'b0;
                  chg        <= 7'd0;
                  rpos       <= 16'd0;
                end
                state <= B_HIST;
              end
            endcase
          end
        end
        B_HIST:   state <= B_HIST_W;
        B_HIST_W: begin
          if (!div_busy) begin
            hist  <= div_r[CTXW-1:0];
            state <= B_POS;
          end
        end
        B_POS:   state <= B_POS_W;
        B_POS_W: begin
          if (!div_busy) begin
            pb    <= (div_q >= 32'(cfg.position_buckets)) ?
                     cfg.position_buckets - 5'd1 : div_q[4:0];
            state <= B_CTX1;
          end
        end
        B_CTX1: begin
          ctx   <= CTXW'(hist * CTXW'(cfg.position_buckets) + CTXW'(pb));
          state <= B_CTX2;
        end
        B_CTX2: begin
          ctx   <= CTXW'(ctx * CTXW'(cfg.change_buckets) + CTXW'(db));
          state <= B_BASE;
        end
        B_BASE: begin
          base     <= AW'(32'(ctx) * 32'(MAX_SYMBOLS));
          idx      <= '0;
          rvalid_d <= 1'b0;
          tot      <= '0;
          lo       <= '0;
          fv       <= 16'd0;
          state    <= B_SUM;
        end
        B_SUM: begin
          // reads stream one per cycle, data lands in the next cycle
          if (rvalid_d) begin
            tot <= tot + TW'(rd_data);
            if (ridx7 < 7'(sym)) begin
              lo <= lo + TW'(rd_data);
            end
            if (ridx7 == 7'(sym)) begin
              fv <= rd_data;
            end
          end
          if (idx7 < cfg.alphabet_size) begin
            idx      <= idx + SW'(1);
            ridx     <= idx;
            rvalid_d <= 1'b1;
          end else begin
            rvalid_d <= 1'b0;
            if (!rvalid_d) begin
              state <= B_RDIV;
            end
          end
        end
        B_RDIV:   state <= B_RDIV_W;
        B_RDIV_W: begin
          if (!div_busy) begin
            r     <= div_q;
            state <= B_MUL;
          end
        end
        B_MUL: begin
          low         <= 33'(low + 33'(32'(lo * r)));
          coder_range <= 32'(r * fv);
          state       <= B_NORM;
        end
        B_NORM: begin
          if (coder_range < RANGE_MIN) begin
            if (can_shift) begin
              coder_range <= {coder_range[23:0], 8'd0};
            end
          end else begin
            state <= B_WRSYM;
          end
        end
        B_WRSYM: begin
          idx      <= '0;
          rvalid_d <= 1'b0;
          state    <= (32'(tot) + 32'(FREQ_STEP) > 32'(FREQ_LIMIT)) ? B_HALVE : B_HMUL;
        end
        B_HALVE: begin
          if (idx7 < cfg.alphabet_size) begin
            idx      <= idx + SW'(1);
            ridx     <= idx;
            rvalid_d <= 1'b1;
          end else begin
            rvalid_d <= 1'b0;
            if (!rvalid_d) begin
              state <= B_HMUL;
            end
          end
        end
        B_HMUL: begin
          hprod <= (CTXW+7)'(hist) * (CTXW+7)'(cfg.alphabet_size) + (CTXW+7)'(sym);
          state <= B_HMOD;
        end
        B_HMOD:   state <= B_HMOD_W;
        B_HMOD_W: begin
          if (!div_busy) begin
            hist_idx <= div_r[CTXW-1:0];
            if (prev_valid && (prev_sym != sym) && (chg < 7'd127)) begin
              chg <= chg + 7'd1;
            end
            prev_sym   <= sym;
            prev_valid <= 1'b1;
            if (rpos != 16'hFFFF) begin
              rpos <= rpos + 16'd1;
            end
            state <= B_FIN;
          end
        end
        B_FLUSH: begin
          if (can_shift) begin
            nshift <= nshift + 3'd1;
            if (nshift == 3'd4) begin
              low         <= '0;
              coder_range <= RANGE_INIT;
              cached      <= 8'd0;
              pending     <= 32'd1;
              state       <= B_FIN;
            end
          end
        end
        B_ERR: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_item.lead_byte     <= 8'd0;
            out_item.fill_byte     <= 8'd0;
            out_item.fill_count    <= 32'd0;
            out_item.context_error <= 1'b1;
            out_item.last          <= 1'b1;
            state                  <= B_IDLE;
          end
        end
        B_FIN: begin
          if (!held_valid) begin
            state <= B_IDLE;
          end else if (out_free) begin
            out_valid     <= 1'b1;
            out_item      <= held;
            out_item.last <= 1'b1;
            held_valid    <= 1'b0;
            state         <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/context_modeled_range_encoder.sv =====
// ----------------------------------------------------------------------------
// context_modeled_range_encoder
// Adaptive frequency context range coder for quality symbols.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------
//   in       | input     | in_valid / in_ready  | in_item  (opcode, symbol,
//            |           |                      |           read_start)
//   out      | output    | out_valid / out_ready| out_item (lead/fill bytes,
//            |           |                      |  count, error, last)
//   cfg      | input     | cfg_we (no wait)     | cfg_index, cfg_data
//
// an encode request uses the divider four times (a start state and a wait
// state each), reads the store over the alphabet for the model sum and
// again when the model is rescaled, and runs control states plus the coder
// shifts in B_NORM; the shared 32 bit divider and the single read port of
// the store set its pace; a flush request does five coder shifts and an
// error request passes on one error result
// after reset a clearing pass writes every store entry to one, with in_ready
// low meanwhile; the front classifies the next request while the coder works;
// a stalled output holds the coder only when a new result must be passed on
// ----------------------------------------------------------------------------
`default_nettype none

module context_modeled_range_encoder #(
  parameter int MAX_CONTEXTS = cmre_pkg::DEF_MAX_CONTEXTS,
  parameter int MAX_SYMBOLS  = cmre_pkg::DEF_MAX_SYMBOLS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire cmre_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output cmre_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [15:0]         cfg_data
);
  import cmre_pkg::*;

  cfg_t cfg;
  logic back_ready;   // clearing pass finished
  logic q_in_valid;
  logic q_in_ready;
  cmd_t q_in_cmd;
  logic q_out_valid;
  logic q_out_ready;
  cmd_t q_out_cmd;

  // configuration registers; the user must write them only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alphabet_size    <= 7'd8;
      cfg.history_order    <= 2'd2;
      cfg.position_buckets <= 5'd8;
      cfg.change_buckets   <= 7'd8;
      cfg.max_read_length  <= 16'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ALPHABET:   cfg.alphabet_size    <= cfg_data[6:0];
        REG_HISTORY:    cfg.history_order    <= cfg_data[1:0];
        REG_POS_BUCKET: cfg.position_buckets <= cfg_data[4:0];
        REG_CHG_BUCKET: cfg.change_buckets   <= cfg_data[6:0];
        REG_MAX_READ:   cfg.max_read_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: context count check, bad symbol drop, request kind
  cmre_front #(
    .MAX_CONTEXTS (MAX_CONTEXTS),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .enable    (back_ready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .cmd_valid (q_in_valid),
    .cmd_ready (q_in_ready),
    .cmd       (q_in_cmd)
  );

  // decoupling queue
  cmre_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_in_valid),
    .push_ready (q_in_ready),
    .push_cmd   (q_in_cmd),
    .pop_valid  (q_out_valid),
    .pop_ready  (q_out_ready),
    .pop_cmd    (q_out_cmd)
  );

  // back: range coder with the frequency store and output register
  cmre_back #(
    .MAX_CONTEXTS (MAX_CONTEXTS),
    .MAX_SYMBOLS  (MAX_SYMBOLS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .ready_for_items (back_ready),
    .cmd_valid       (q_out_valid),
    .cmd_ready       (q_out_ready),
    .cmd             (q_out_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_item        (out_item)
  );

endmodule

`default_nettype wire

// ===== verif/tb_context_modeled_range_encoder.sv =====
// ----------------------------------------------------------------------------
// tb_context_modeled_range_encoder
// Self-checking bench: random and directed symbol streams under several
// context settings, with results predicted by a behavioral coder model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_context_modeled_range_encoder;
  timeunit 1ns;
  timeprecision 1ps;
  import cmre_pkg::*;

  localparam int TAB_DEPTH  = DEF_MAX_CONTEXTS * DEF_MAX_SYMBOLS;
  localparam int IDLE_LIMIT = 1000000;  // well above the store clearing pass
  localparam int DRAIN_WAIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_ALPHABET;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  context_modeled_range_encoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted coder state
  cfg_t        cur_cfg;
  logic [32:0] c_low;
  logic [31:0] c_range;
  logic [7:0]  c_cache;
  logic [31:0] c_pending;
  int unsigned hist_idx, prev_sym, chg_cnt, rd_pos;
  bit          prev_ok;
  logic [15:0] freq_tab [0:TAB_DEPTH-1];

  in_item_t  request_q[$];   // requests waiting for the driver
  out_item_t expected_q[$];  // predicted results not yet seen
  int        mismatches = 0;
  int        results_seen = 0;
  bit        burst = 1'b0;   // no idling on either side while set
  int        idle_cycles = 0;

  // one coder shift; a byte leaves whenever the top byte is settled
  function automatic void shift_byte(ref out_item_t res[$]);
    logic [31:0] lo32;
    logic        carry;
    out_item_t   r;
    lo32  = c_low[31:0];
    carry = c_low[32];
    if (carry || lo32 < EMIT_LIMIT) begin
      if (res.size() < 5) begin
        r.lead_byte     = 8'(c_cache + carry);
        r.fill_byte     = 8'(8'hFF + carry);
        r.fill_count    = c_pending - 32'd1;
        r.context_error = 1'b0;
        r.last          = 1'b0;
        res.insert(res.size(), r);
      end
      c_cache   = lo32[31:24];
      c_pending = '0;
    end
    c_pending = c_pending + 32'd1;
    c_low     = {1'b0, lo32 << 8};
  endfunction

  function automatic void clear_coder();
    c_low     = '0;
    c_range   = RANGE_INIT;
    c_cache   = '0;
    c_pending = 32'd1;
  endfunction

  // works out the results of one accepted request and queues them
  function automatic void encode_request(in_item_t it);
    out_item_t       res[$];
    out_item_t       er;
    longint unsigned hs, ctx_count, lo_r;
    int unsigned     alpha, hist, pb, db, scale, ctx, base, tot, lo, fv, r, s;
    alpha = cur_cfg.alphabet_size;
    s     = it.symbol;
    if (it.opcode == OP_FLUSH) begin
      for (int i = 0; i < 5; i++) shift_byte(res);
      clear_coder();
    end else begin
      hs = 1;
      for (int i = 0; i < cur_cfg.history_order; i++) hs = hs * alpha;
      ctx_count = hs * cur_cfg.position_buckets * cur_cfg.change_buckets;
      if (alpha == 0 || alpha > DEF_MAX_SYMBOLS || cur_cfg.position_buckets == 0 ||
          cur_cfg.change_buckets == 0 || ctx_count > DEF_MAX_CONTEXTS) begin
        er = '0;
        er.context_error = 1'b1;
        res.insert(res.size(), er);
      end else if (s < alpha) begin
        if (it.read_start) begin
          hist_idx = 0; prev_ok = 1'b0; chg_cnt = 0; rd_pos = 0;
        end
        hist  = int'(hist_idx % hs);
        scale = (cur_cfg.max_read_length != 0) ? cur_cfg.max_read_length : 1;
        pb    = rd_pos * cur_cfg.position_buckets / scale;
        if (pb >= cur_cfg.position_buckets) pb = cur_cfg.position_buckets - 1;
        db    = (chg_cnt >= cur_cfg.change_buckets) ? cur_cfg.change_buckets - 1 : chg_cnt;
        ctx   = (hist * cur_cfg.position_buckets + pb) * cur_cfg.change_buckets + db;
        base  = ctx * DEF_MAX_SYMBOLS;
        tot = 0; lo = 0;
        for (int i = 0; i < alpha; i++) begin
          tot += freq_tab[base + i];
          if (i < s) lo += freq_tab[base + i];
        end
        fv      = freq_tab[base + s];
        r       = c_range / tot;
        lo_r    = longint'(lo) * r;
        c_low   = 33'(c_low + lo_r);
        c_range = 32'(r * fv);
        while (c_range < RANGE_MIN) begin
          c_range = c_range << 8;
          shift_byte(res);
        end
        freq_tab[base + s] = 16'(fv + FREQ_STEP);
        // rescale: halve the whole model, keep every entry odd
        if (tot + FREQ_STEP > FREQ_LIMIT)
          for (int i = 0; i < alpha; i++)
            freq_tab[base + i] = (freq_tab[base + i] >> 1) | 16'd1;
        hist_idx = int'((longint'(hist) * alpha + s) % hs);
        if (prev_ok && prev_sym != s && chg_cnt < 127) chg_cnt++;
        prev_sym = s;
        prev_ok  = 1'b1;
        if (rd_pos < 65535) rd_pos++;
      end
    end
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_q.insert(expected_q.size(), res[i]);
  endfunction

  // request driver: per-request random gap, payload held until accepted
  int gap_left = 0;
  always @(posedge clk) begin
    logic v;
    v = in_valid;
    if (in_valid && in_ready) begin
      encode_request(in_item);
      v = 1'b0;
    end
    if (!v) begin
      if (gap_left > 0) gap_left--;
      else if (request_q.size() > 0) begin
        in_item  <= request_q.pop_front();
        v        = 1'b1;
        gap_left = burst ? 0 : $urandom_range(0, 7);
      end
    end
    in_valid <= v;
  end

  // result monitor and receiver stalls; one long stall fills the block up
  int hold_left = 0;
  always @(posedge clk) begin
    logic      rdy;
    out_item_t exp_item;
    rdy = out_ready;
    if (out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item);
      end else begin
        exp_item = expected_q.pop_front();
        if (out_item.lead_byte !== exp_item.lead_byte ||
            out_item.fill_byte !== exp_item.fill_byte ||
            out_item.fill_count !== exp_item.fill_count ||
            out_item.context_error !== exp_item.context_error ||
            out_item.last !== exp_item.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected %p, got %p", results_seen, exp_item, out_item);
        end
      end
      rdy = 1'b0;
      if (results_seen == 30) hold_left = 3000;
      else hold_left = burst ? 0 : $urandom_range(0, 7);
    end
    if (!rdy) begin
      if (hold_left > 0) hold_left--;
      else rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  // watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic write_config(cfg_t c);
    logic [15:0] vals [5];
    vals[0] = 16'(c.alphabet_size);
    vals[1] = 16'(c.history_order);
    vals[2] = 16'(c.position_buckets);
    vals[3] = 16'(c.change_buckets);
    vals[4] = c.max_read_length;
    for (int i = 0; i < 5; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
    end
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic wait_idle();
    wait (request_q.size() == 0 && !in_valid && expected_q.size() == 0);
    // requests with no result may still be in flight in front, queue and coder
    repeat (DRAIN_WAIT) @(posedge clk);
    wait (expected_q.size() == 0);
  endtask

  function automatic void push_req(bit op, int s, bit rs);
    in_item_t it;
    it.opcode     = op;
    it.symbol     = 6'(s);
    it.read_start = rs;
    request_q.insert(request_q.size(), it);
  endfunction

  // well-formed reads with random symbols, sprinkled with noise and flushes
  function automatic void random_reads(int n_items, int alpha);
    int left;
    left = 0;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 19) == 0) push_req(OP_FLUSH, $urandom_range(0, 63), $urandom_range(0, 1));
      else if ($urandom_range(0, 14) == 0) push_req(OP_ENCODE, $urandom_range(0, 63), $urandom_range(0, 1));
      else begin
        push_req(OP_ENCODE, $urandom_range(0, alpha - 1), left == 0);
        left = (left == 0) ? $urandom_range(1, 40) : left - 1;
      end
    end
  endfunction

  initial begin
    cfg_t c;
    for (int i = 0; i < TAB_DEPTH; i++) freq_tab[i] = 16'd1;
    cur_cfg = '{alphabet_size: 7'd8, history_order: 2'd2, position_buckets: 5'd8,
                change_buckets: 7'd8, max_read_length: 16'd100};
    clear_coder();
    hist_idx = 0; prev_sym = 0; prev_ok = 1'b0; chg_cnt = 0; rd_pos = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset settings: flush of a fresh coder, range edges, ignored symbols
    push_req(OP_FLUSH, 0, 0);
    push_req(OP_ENCODE, 0, 1);
    push_req(OP_ENCODE, 7, 0);
    push_req(OP_ENCODE, 8, 0);
    push_req(OP_ENCODE, 63, 1);
    push_req(OP_ENCODE, 7, 0);
    push_req(OP_ENCODE, 0, 0);
    push_req(OP_FLUSH, 63, 1);
    push_req(OP_FLUSH, 0, 0);
    random_reads(80, 8);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();

    // widest alphabet, no history, widest position scale
    c = '{alphabet_size: 7'd64, history_order: 2'd0, position_buckets: 5'd16,
          change_buckets: 7'd4, max_read_length: 16'hFFFF};
    write_config(c);
    burst = 1'b1;
    push_req(OP_ENCODE, 63, 1);
    push_req(OP_ENCODE, 0, 0);
    random_reads(40, 64);
    wait (request_q.size() == 0);
    burst = 1'b0;
    random_reads(40, 64);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();

    // single context, single symbol: one model used over and over
    c = '{alphabet_size: 7'd1, history_order: 2'd3, position_buckets: 5'd1,
          change_buckets: 7'd1, max_read_length: 16'd0};
    write_config(c);
    push_req(OP_ENCODE, 1, 0);
    for (int i = 0; i < 40; i++) push_req(OP_ENCODE, 0, i % 15 == 0);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();

    // context count right at the limit codes, then zero alphabet or buckets: error results
    c = '{alphabet_size: 7'd64, history_order: 2'd1, position_buckets: 5'd8,
          change_buckets: 7'd8, max_read_length: 16'd100};
    write_config(c);
    push_req(OP_ENCODE, 3, 1);
    push_req(OP_ENCODE, 63, 0);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();
    c = '{alphabet_size: 7'd0, history_order: 2'd0, position_buckets: 5'd16,
          change_buckets: 7'd64, max_read_length: 16'd100};
    write_config(c);
    push_req(OP_ENCODE, 0, 0);
    wait_idle();
    c = '{alphabet_size: 7'd127, history_order: 2'd0, position_buckets: 5'd0,
          change_buckets: 7'd127, max_read_length: 16'd100};
    write_config(c);
    push_req(OP_ENCODE, 0, 1);
    wait_idle();

    // deep history, short reads so every bucket boundary gets crossed
    c = '{alphabet_size: 7'd5, history_order: 2'd3, position_buckets: 5'd2,
          change_buckets: 7'd2, max_read_length: 16'd7};
    write_config(c);
    random_reads(80, 5);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();

    // back near reset settings with stored history reduced to a new space
    c = '{alphabet_size: 7'd16, history_order: 2'd1, position_buckets: 5'd16,
          change_buckets: 7'd16, max_read_length: 16'd1};
    write_config(c);
    random_reads(60, 16);
    push_req(OP_FLUSH, 0, 0);
    wait_idle();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
